### rtl/dpam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpam_pkg
// Types and codes shared by the dense polynomial add/multiply block.
// ----------------------------------------------------------------------------
package dpam_pkg;

  localparam int IDX_W  = 6;
  localparam int COEF_W = 32;
  localparam int DEPTH  = 1 << IDX_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [2:0]        func_t;
  typedef logic [1:0]        err_t;

  localparam func_t FUNC_CLEAR  = 3'd0;
  localparam func_t FUNC_LOAD_A = 3'd1;
  localparam func_t FUNC_LOAD_B = 3'd2;
  localparam func_t FUNC_ADD    = 3'd3;
  localparam func_t FUNC_MUL    = 3'd4;

  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_PRODUCT  = 2'd1;
  localparam err_t ERR_EXPONENT = 2'd2;

  // tag that travels with a coefficient pair through the MAC
  typedef struct packed {
    logic vld;
    logic last;
    idx_t k;
  } mac_tag_t;

  typedef struct packed {
    logic vld;
    idx_t k;
  } mac_wr_t;

endpackage

### rtl/dpam_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpam_if
// Command and result channels of the polynomial block.
// ----------------------------------------------------------------------------
interface dpam_cmd_if;
  import dpam_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  idx_t  exponent;
  coef_t coefficient;
  modport source (output valid, output func, output exponent, output coefficient,
                  input ready);
  modport sink (input valid, input func, input exponent, input coefficient,
                output ready);
endinterface

interface dpam_res_if;
  import dpam_pkg::*;
  logic  valid;
  logic  ready;
  idx_t  degree_index;
  coef_t result_coefficient;
  logic  is_last;
  err_t  error_code;
  modport source (output valid, output degree_index, output result_coefficient,
                  output is_last, output error_code, input ready);
  modport sink (input valid, input degree_index, input result_coefficient,
                input is_last, input error_code, output ready);
endinterface

### rtl/dpam_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpam_mac
// Shared multiply-accumulate unit: registered 32x32 product, then an
// accumulator that is flushed on the last pair of each output coefficient.
// ----------------------------------------------------------------------------
module dpam_mac (
  input  logic              clk,
  input  logic              rst,
  input  dpam_pkg::mac_tag_t tag,
  input  dpam_pkg::coef_t   a,
  input  dpam_pkg::coef_t   b,
  output dpam_pkg::mac_wr_t wr,
  output dpam_pkg::coef_t   wr_data
);
  import dpam_pkg::*;

  mac_tag_t s2;
  coef_t    prod;
  coef_t    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2  <= '0;
      acc <= '0;
    end else begin
      s2 <= tag;
      if (s2.vld) begin
        acc <= s2.last ? '0 : acc + prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  assign wr.vld  = s2.vld && s2.last;
  assign wr.k    = s2.k;
  assign wr_data = acc + prod;

endmodule

### rtl/dense_polynomial_add_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_polynomial_add_multiply
// Two dense polynomials with in-place add and multiply.
//
// cmd takes one transaction at a time: clear, load first, load second, add or
// multiply. cmd.ready is high only while the sequencer is idle. Clear and
// loads finish in the cycle they are taken and give no result. Add and
// multiply replace the first operand and stream its d+1 coefficients on
// result, degree 0 first, is_last on the top one. A bad load exponent or an
// oversized product gives a single error transaction instead.
// Multiply sends (da+1)*(db+1) pairs through the one shared MAC at one pair a
// cycle, drains the MAC pipeline, then emits and copies back from the product
// memory. Each result coefficient is a memory read, then the write-back into
// the output register. When result stalls, the sequencer holds in the
// write-back step; nothing is dropped.
// Reset clears both operands (per-entry valid bits) and the degrees at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module dense_polynomial_add_multiply #(
  parameter int MAX_DEGREE = 63
) (
  input logic        clk,
  input logic        rst,
  dpam_cmd_if.sink   cmd,
  dpam_res_if.source result
);
  import dpam_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ERR   = 6'b000010,
    S_ISSUE = 6'b000100,
    S_DRAIN = 6'b001000,
    S_RD    = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

  localparam logic [IDX_W:0] MAX_D = (IDX_W+1)'(MAX_DEGREE);

  state_t           state;
  idx_t             first_deg, second_deg, tgt_deg;
  idx_t             k, i;
  logic             emit_add;
  err_t             err_q;
  logic [DEPTH-1:0] first_vld, second_vld;

  coef_t first_mem  [DEPTH];
  coef_t second_mem [DEPTH];
  coef_t prod_mem   [DEPTH];

  coef_t    a_q, b_q, p_q;
  logic     a_vq, b_vq;
  coef_t    a_val, b_val, emit_val;
  idx_t     a_addr, b_addr, ihi, kn, ilo_n, max_deg;
  logic     rd_en, take, out_free, commit, load_ok;
  logic [IDX_W:0] prod_deg;
  logic     first_we;
  idx_t     first_wa;
  coef_t    first_wd;
  mac_tag_t s1;
  mac_wr_t  mac_wr;
  coef_t    mac_data;

  logic     out_vld, out_last;
  idx_t     out_idx;
  coef_t    out_coef;
  err_t     out_err;

  assign take     = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !out_vld || result.ready;
  assign commit   = (state == S_WB) && out_free;
  assign load_ok  = {1'b0, cmd.exponent} <= MAX_D;
  assign prod_deg = {1'b0, first_deg} + {1'b0, second_deg};
  assign max_deg  = (first_deg > second_deg) ? first_deg : second_deg;

  assign ihi   = (k < first_deg) ? k : first_deg;
  assign kn    = k + idx_t'(1);
  assign ilo_n = (kn > second_deg) ? kn - second_deg : '0;

  assign rd_en  = (state == S_ISSUE) || (state == S_RD);
  assign a_addr = (state == S_ISSUE) ? i : k;
  assign b_addr = (state == S_ISSUE) ? k - i : k;

  assign a_val    = a_vq ? a_q : '0;
  assign b_val    = b_vq ? b_q : '0;
  assign emit_val = emit_add ? a_val + b_val : p_q;

  always_comb begin
    first_we = 1'b0;
    first_wa = k;
    first_wd = emit_val;
    if (commit) begin
      first_we = 1'b1;
    end else if (take && cmd.func == FUNC_LOAD_A && load_ok) begin
      first_we = 1'b1;
      first_wa = cmd.exponent;
      first_wd = cmd.coefficient;
    end
  end

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    if (take && cmd.func == FUNC_LOAD_B && load_ok) begin
      second_mem[cmd.exponent] <= cmd.coefficient;
    end
    if (mac_wr.vld) prod_mem[mac_wr.k] <= mac_data;
    if (rd_en) begin
      a_q  <= first_mem[a_addr];
      b_q  <= second_mem[b_addr];
      p_q  <= prod_mem[k];
      a_vq <= first_vld[a_addr];
      b_vq <= second_vld[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vld  <= '0;
      second_vld <= '0;
    end else if (take && cmd.func == FUNC_CLEAR) begin
      first_vld  <= '0;
      second_vld <= '0;
    end else begin
      if (first_we) first_vld[first_wa] <= 1'b1;
      if (take && cmd.func == FUNC_LOAD_B && load_ok) second_vld[cmd.exponent] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1.vld  <= (state == S_ISSUE);
      s1.last <= (i == ihi);
      s1.k    <= k;
    end
  end

  dpam_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag     (s1),
    .a       (a_val),
    .b       (b_val),
    .wr      (mac_wr),
    .wr_data (mac_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_deg  <= '0;
      second_deg <= '0;
      tgt_deg    <= '0;
      k          <= '0;
      i          <= '0;
      emit_add   <= 1'b0;
      err_q      <= ERR_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.func)
              FUNC_CLEAR: begin
                first_deg  <= '0;
                second_deg <= '0;
              end
              FUNC_LOAD_A, FUNC_LOAD_B: begin
                if (!load_ok) begin
                  err_q <= ERR_EXPONENT;
                  state <= S_ERR;
                end else if (cmd.func == FUNC_LOAD_A) begin
                  if (cmd.exponent > first_deg) first_deg <= cmd.exponent;
                end else begin
                  if (cmd.exponent > second_deg) second_deg <= cmd.exponent;
                end
              end
              FUNC_ADD: begin
                first_deg <= max_deg;
                k         <= '0;
                emit_add  <= 1'b1;
                state     <= S_RD;
              end
              FUNC_MUL: begin
                if (prod_deg > MAX_D) begin
                  err_q <= ERR_PRODUCT;
                  state <= S_ERR;
                end else begin
                  tgt_deg <= prod_deg[IDX_W-1:0];
                  k       <= '0;
                  i       <= '0;
                  state   <= S_ISSUE;
                end
              end
              default: ;
            endcase
          end
        end
        S_ERR: begin
          if (out_free) state <= S_IDLE;
        end
        S_ISSUE: begin
          if (i == ihi) begin
            if (k == tgt_deg) begin
              state <= S_DRAIN;
            end else begin
              k <= kn;
              i <= ilo_n;
            end
          end else begin
            i <= i + idx_t'(1);
          end
        end
        S_DRAIN: begin
          if (mac_wr.vld && mac_wr.k == tgt_deg) begin
            first_deg <= tgt_deg;
            k         <= '0;
            emit_add  <= 1'b0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WB;
        end
        S_WB: begin
          if (commit) begin
            if (k == first_deg) begin
              state <= S_IDLE;
            end else begin
              k     <= kn;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (commit || (state == S_ERR && out_free)) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_idx  <= k;
      out_coef <= emit_val;
      out_last <= (k == first_deg);
      out_err  <= ERR_NONE;
    end else if (state == S_ERR && out_free) begin
      out_idx  <= '0;
      out_coef <= '0;
      out_last <= 1'b1;
      out_err  <= err_q;
    end
  end

  assign result.valid              = out_vld;
  assign result.degree_index       = out_idx;
  assign result.result_coefficient = out_coef;
  assign result.is_last            = out_last;
  assign result.error_code         = out_err;

`ifndef NO_ASSERTIONS
  a_mac_only_mul: assert property (@(posedge clk) disable iff (rst)
    mac_wr.vld |-> (state == S_ISSUE || state == S_DRAIN))
    else $error("MAC write outside multiply");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.error_code != ERR_NONE) |->
      (result.is_last && result.result_coefficient == '0))
    else $error("error result malformed");

  a_idle_empty_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (!s1.vld && !mac_wr.vld))
    else $error("command taken with MAC busy");

  a_wb_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> (state == S_WB))
    else $error("read step not followed by write-back");
`endif

endmodule

### test/dpam_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpam_tb_if
// The testbench uses the command and result interfaces of the block itself;
// no testbench-only channel is declared here.
// ----------------------------------------------------------------------------

### test/dpam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpam_checker
// Watches both channels, keeps a shadow copy of the two operands, works out
// the coefficients each add or multiply must stream out, and each error result,
// and compares them in order with what the block emits.
// ----------------------------------------------------------------------------
module dpam_checker #(
  parameter int MAX_DEGREE = 63
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  logic            cmd_ready,
  input  dpam_pkg::func_t cmd_func,
  input  dpam_pkg::idx_t  cmd_exponent,
  input  dpam_pkg::coef_t cmd_coefficient,
  input  logic            res_valid,
  input  logic            res_ready,
  input  dpam_pkg::idx_t  res_degree_index,
  input  dpam_pkg::coef_t res_coefficient,
  input  logic            res_is_last,
  input  dpam_pkg::err_t  res_error_code,
  output int              fail_count,
  output int              pending_count,
  output int              coeff_count,
  output int              error_count
);
  import dpam_pkg::*;

  typedef struct packed {
    idx_t  idx;
    coef_t coef;
    logic  last;
    err_t  err;
  } poly_term_t;

  coef_t poly_a [DEPTH];
  coef_t poly_b [DEPTH];
  int    deg_a, deg_b;
  poly_term_t terms_due[$];

  task automatic push_error(err_t e);
    terms_due.push_back('{idx: '0, coef: '0, last: 1'b1, err: e});
  endtask

  task automatic push_poly_a();
    for (int k = 0; k <= deg_a; k++)
      terms_due.push_back('{idx: idx_t'(k), coef: poly_a[k], last: k == deg_a,
                            err: ERR_NONE});
  endtask

  task automatic apply_cmd(func_t f, idx_t e, coef_t c);
    coef_t prod [DEPTH];
    case (f)
      FUNC_CLEAR: begin
        foreach (poly_a[k]) begin
          poly_a[k] = '0;
          poly_b[k] = '0;
        end
        deg_a = 0;
        deg_b = 0;
      end
      FUNC_LOAD_A, FUNC_LOAD_B: begin
        if (e > MAX_DEGREE) begin
          push_error(ERR_EXPONENT);
        end else if (f == FUNC_LOAD_A) begin
          poly_a[e] = c;
          if (e > deg_a) deg_a = e;
        end else begin
          poly_b[e] = c;
          if (e > deg_b) deg_b = e;
        end
      end
      FUNC_ADD: begin
        if (deg_b > deg_a) deg_a = deg_b;
        for (int k = 0; k <= deg_a; k++) poly_a[k] = poly_a[k] + poly_b[k];
        push_poly_a();
      end
      FUNC_MUL: begin
        if (deg_a + deg_b > MAX_DEGREE) begin
          push_error(ERR_PRODUCT);
        end else begin
          foreach (prod[k]) prod[k] = '0;
          for (int i = 0; i <= deg_a; i++)
            for (int j = 0; j <= deg_b; j++)
              prod[i + j] = prod[i + j] + poly_a[i] * poly_b[j];
          poly_a = prod;
          deg_a = deg_a + deg_b;
          push_poly_a();
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_term();
    poly_term_t exp_t;
    if (terms_due.size() == 0) begin
      $error("unexpected result transaction: idx %0d coef %0h",
             res_degree_index, res_coefficient);
      fail_count++;
      return;
    end
    exp_t = terms_due.pop_front();
    if (res_degree_index !== exp_t.idx) begin
      $error("degree_index: expected %0d actual %0d", exp_t.idx, res_degree_index);
      fail_count++;
    end
    if (res_coefficient !== exp_t.coef) begin
      $error("result_coefficient: expected %0h actual %0h", exp_t.coef, res_coefficient);
      fail_count++;
    end
    if (res_is_last !== exp_t.last) begin
      $error("is_last: expected %0b actual %0b", exp_t.last, res_is_last);
      fail_count++;
    end
    if (res_error_code !== exp_t.err) begin
      $error("error_code: expected %0d actual %0d", exp_t.err, res_error_code);
      fail_count++;
    end
    if (exp_t.err != ERR_NONE) error_count++;
    else coeff_count++;
  endtask

  initial begin
    fail_count = 0;
    coeff_count = 0;
    error_count = 0;
    deg_a = 0;
    deg_b = 0;
    foreach (poly_a[k]) begin
      poly_a[k] = '0;
      poly_b[k] = '0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) compare_term();
      if (cmd_valid && cmd_ready) apply_cmd(cmd_func, cmd_exponent, cmd_coefficient);
    end
  end

  assign pending_count = terms_due.size();

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command transactions into the polynomial block: directed loads,
// adds, multiplies and error cases, then mostly well-formed random load and
// compute sequences. The result side stalls at random and once for a long
// stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import dpam_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count, coeff_count, error_count;
  int   src_idle_pct = 31;
  int   snk_idle_pct = 47;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;
  int   cmds_sent = 0;

  dpam_cmd_if cmd ();
  dpam_res_if result ();

  always #5 clk = ~clk;

  dense_polynomial_add_multiply #(.MAX_DEGREE(63)) DUT (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .result(result.source)
  );

  dpam_checker #(.MAX_DEGREE(63)) chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_func(cmd.func),
    .cmd_exponent(cmd.exponent), .cmd_coefficient(cmd.coefficient),
    .res_valid(result.valid), .res_ready(result.ready),
    .res_degree_index(result.degree_index), .res_coefficient(result.result_coefficient),
    .res_is_last(result.is_last), .res_error_code(result.error_code),
    .fail_count(fail_count), .pending_count(pending_count),
    .coeff_count(coeff_count), .error_count(error_count)
  );

  initial begin
    cmd.valid = 1'b0;
    cmd.func = FUNC_CLEAR;
    cmd.exponent = '0;
    cmd.coefficient = '0;
    result.ready = 1'b0;
  end

  // result side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (result.valid && result.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one command; random gap first, then hold until accepted
  task automatic send_cmd(func_t f, idx_t e, coef_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.func <= f;
    cmd.exponent <= e;
    cmd.coefficient <= c;
    do @(posedge clk); while (!cmd.ready);
    cmds_sent++;
  endtask

  function automatic coef_t rand_coef();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return coef_t'($urandom_range(7));
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic load_random(func_t f, int max_deg);
    int n;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++)
      send_cmd(f, idx_t'($urandom_range(max_deg)), rand_coef());
  endtask

  task automatic random_phase(int n_cmds);
    int sel;
    for (int k = 0; k < n_cmds; k++) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        send_cmd(FUNC_CLEAR, idx_t'($urandom), coef_t'($urandom));
        load_random(FUNC_LOAD_A, 7);
        load_random(FUNC_LOAD_B, 7);
        send_cmd(FUNC_MUL, '0, '0);
      end else if (sel < 25) begin
        load_random(FUNC_LOAD_B, 15);
        send_cmd(FUNC_ADD, idx_t'($urandom), coef_t'($urandom));
      end else if (sel < 40) begin
        send_cmd(FUNC_CLEAR, '0, '0);
        load_random(FUNC_LOAD_A, 4);
        load_random(FUNC_LOAD_B, 4);
        send_cmd(FUNC_MUL, '0, '0);
      end else if (sel < 50) begin
        send_cmd(FUNC_MUL, '0, '0);
      end else if (sel < 55) begin
        send_cmd(func_t'($urandom_range(7, 5)), idx_t'($urandom), coef_t'($urandom));
      end else begin
        send_cmd(func_t'($urandom_range(FUNC_ADD, FUNC_LOAD_A)),
                 idx_t'($urandom), rand_coef());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both operands, add, multiply, oversize product
    send_cmd(FUNC_ADD, '0, '0);
    send_cmd(FUNC_MUL, '0, '0);
    send_cmd(FUNC_LOAD_A, '0, 32'h7fff_ffff);
    send_cmd(FUNC_LOAD_B, '0, 32'h8000_0000);
    send_cmd(FUNC_ADD, '0, '0);
    send_cmd(FUNC_LOAD_A, 6'd63, 32'hffff_ffff);
    send_cmd(FUNC_LOAD_B, 6'd63, 32'h0000_0001);
    send_cmd(FUNC_ADD, 6'd63, 32'hffff_ffff);
    send_cmd(FUNC_MUL, '0, '0);
    send_cmd(FUNC_CLEAR, 6'd63, 32'hffff_ffff);
    send_cmd(FUNC_LOAD_A, 6'd31, 32'h8000_0000);
    send_cmd(FUNC_LOAD_B, 6'd32, 32'hffff_ffff);
    send_cmd(FUNC_MUL, '0, '0);
    send_cmd(FUNC_LOAD_B, 6'd1, 32'h5555_aaaa);
    send_cmd(FUNC_MUL, '0, '0);
    send_cmd(3'd5, 6'd63, 32'hffff_ffff);
    send_cmd(3'd7, '0, '0);
    send_cmd(FUNC_CLEAR, '0, '0);
    send_cmd(FUNC_LOAD_A, 6'd1, 32'd3);
    send_cmd(FUNC_LOAD_B, 6'd2, 32'hffff_fffe);
    send_cmd(FUNC_MUL, '0, '0);

    // long result hold-off while the sender keeps going
    hold_cycles = 400;
    send_cmd(FUNC_ADD, '0, '0);
    send_cmd(FUNC_ADD, '0, '0);
    send_cmd(FUNC_LOAD_B, 6'd4, 32'd9);

    random_phase(14);
    src_idle_pct = 47;
    snk_idle_pct = 31;
    random_phase(14);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(14);
    cmd.valid <= 1'b0;

    while (pending_count > 0) @(posedge clk);
    repeat (5000) @(posedge clk);

    $display("sent %0d commands; checked %0d coefficients and %0d error results",
             cmds_sent, coeff_count, error_count);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
